// ----- rtl/mbld_pkg.sv -----
`default_nettype none
package mbld_pkg;

    localparam int MAX_BUTTONS     = 16;
    localparam int DEF_BUTTONS     = 16;
    localparam int DEF_TIMER_BITS  = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int BUTTON_IDX_BITS = 4;
    localparam int INTERVAL_BITS   = 16;
    localparam int CFG_DATA_BITS   = 64;
    localparam int CFG_IDX_BITS    = 3;
    localparam int LANES_PER_WORD  = CFG_DATA_BITS / INTERVAL_BITS;

    localparam logic [CFG_IDX_BITS-1:0] REG_BUTTON_ENABLE = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_INTERVAL_0    = 3'd1;

    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_SAMPLE = 1'b1;

    typedef struct packed {
        logic tick;
        logic sample;
    } lane_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/mbld_lane.sv -----
`default_nettype none
module mbld_lane #(
    parameter int TIMER_BITS = mbld_pkg::DEF_TIMER_BITS
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire mbld_pkg::lane_ctrl_t ctrl,
    input  wire                     level,
    input  wire                     enable,
    input  wire  [TIMER_BITS-1:0]   interval,
    output logic                    event_hit
);
    import mbld_pkg::*;

    logic                  stored_reg;
    logic [TIMER_BITS-1:0] timer_reg;
    logic                  timer_zero;

    assign timer_zero = (timer_reg == '0);
    assign event_hit  = enable && timer_zero && (level != stored_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stored_reg <= 1'b0;
            timer_reg  <= '0;
        end else if (ctrl.tick) begin
            if (!timer_zero) begin
                timer_reg <= timer_reg - TIMER_BITS'(1);
            end
        end else if (ctrl.sample) begin
            if (!enable) begin
                stored_reg <= level;
            end else if (event_hit) begin
                stored_reg <= level;
                timer_reg  <= interval;
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/mbld_merge.sv -----
`default_nettype none
module mbld_merge #(
    parameter int BUTTONS = mbld_pkg::DEF_BUTTONS
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       load,
    input  wire  [BUTTONS-1:0]                        load_mask,
    input  wire  [mbld_pkg::SAMPLE_BITS-1:0]          load_sample,
    output logic                                      pending,
    output logic                                      m_valid,
    input  wire                                       m_ready,
    output logic [mbld_pkg::BUTTON_IDX_BITS-1:0]      m_event_button,
    output logic                                      m_event_level,
    output logic [mbld_pkg::SAMPLE_BITS-1:0]          m_event_sample,
    output logic                                      m_last_event
);
    import mbld_pkg::*;

    logic [BUTTONS-1:0]         mask_reg;
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic [BUTTONS-1:0]         remain;
    logic [BUTTON_IDX_BITS-1:0] sel;
    logic                       advance;

    logic                       valid_reg;
    logic [BUTTON_IDX_BITS-1:0] button_reg;
    logic                       level_reg;
    logic [SAMPLE_BITS-1:0]     out_sample_reg;
    logic                       last_reg;

    always_comb begin
        sel = '0;
        for (int i = BUTTONS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                sel = BUTTON_IDX_BITS'(i);
            end
        end
    end

    assign remain  = mask_reg & (mask_reg - BUTTONS'(1));
    assign pending = (mask_reg != '0);
    assign advance = pending && (!valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                mask_reg <= load_mask;
            end else if (advance) begin
                mask_reg <= remain;
            end
            if (advance) begin
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            sample_reg <= load_sample;
        end
        if (advance) begin
            button_reg     <= sel;
            level_reg      <= sample_reg[sel];
            out_sample_reg <= sample_reg;
            last_reg       <= (remain == '0);
        end
    end

    assign m_valid        = valid_reg;
    assign m_event_button = button_reg;
    assign m_event_level  = level_reg;
    assign m_event_sample = out_sample_reg;
    assign m_last_event   = last_reg;

endmodule
`default_nettype wire

// ----- rtl/multi_button_lockout_debouncer.sv -----
`default_nettype none
// Every button has its own lane with a stored level and a lockout timer; all lanes act in the
// cycle an item is accepted. A tick or a sample without events yields no result.
// A sample with events registers its hit mask in the merge stage; each event then moves into the
// output register, one per cycle while m_ready is high; s_ready stays low until the last has moved.
// Synchronous active-low reset clears levels, timers, enables, intervals and the output queue.
module multi_button_lockout_debouncer #(
    parameter int BUTTONS    = mbld_pkg::DEF_BUTTONS,
    parameter int TIMER_BITS = mbld_pkg::DEF_TIMER_BITS
) (
    input  wire                                       aclk,
    input  wire                                       aresetn,
    input  wire                                       cfg_wr_en,
    input  wire  [mbld_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  wire  [mbld_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  wire                                       s_valid,
    output logic                                      s_ready,
    input  wire                                       s_func,
    input  wire  [mbld_pkg::SAMPLE_BITS-1:0]          s_sample_bits,
    output logic                                      m_valid,
    input  wire                                       m_ready,
    output logic [mbld_pkg::BUTTON_IDX_BITS-1:0]      m_event_button,
    output logic                                      m_event_level,
    output logic [mbld_pkg::SAMPLE_BITS-1:0]          m_event_sample,
    output logic                                      m_last_event
);
    import mbld_pkg::*;

    logic [BUTTONS-1:0]    enable_reg;
    logic [TIMER_BITS-1:0] interval_reg [BUTTONS];
    logic [BUTTONS-1:0]    hits;
    logic                  accept;
    logic                  pending;
    lane_ctrl_t            ctrl;

    assign s_ready     = !pending;
    assign accept      = s_valid && s_ready;
    assign ctrl.tick   = accept && (s_func == FUNC_TICK);
    assign ctrl.sample = accept && (s_func == FUNC_SAMPLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
        end else if (cfg_wr_en && (cfg_index == REG_BUTTON_ENABLE)) begin
            enable_reg <= cfg_data[BUTTONS-1:0];
        end
    end

    for (genvar b = 0; b < BUTTONS; b++) begin : g_lane
        localparam int WORD  = b / LANES_PER_WORD;
        localparam int SHIFT = (b % LANES_PER_WORD) * INTERVAL_BITS;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                interval_reg[b] <= '0;
            end else if (cfg_wr_en
                         && (cfg_index == CFG_IDX_BITS'(int'(REG_INTERVAL_0) + WORD))) begin
                interval_reg[b] <= cfg_data[SHIFT +: TIMER_BITS];
            end
        end

        mbld_lane #(
            .TIMER_BITS(TIMER_BITS)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .level     (s_sample_bits[b]),
            .enable    (enable_reg[b]),
            .interval  (interval_reg[b]),
            .event_hit (hits[b])
        );
    end

    mbld_merge #(
        .BUTTONS(BUTTONS)
    ) u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (ctrl.sample),
        .load_mask      (hits),
        .load_sample    (s_sample_bits),
        .pending        (pending),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_button (m_event_button),
        .m_event_level  (m_event_level),
        .m_event_sample (m_event_sample),
        .m_last_event   (m_last_event)
    );

endmodule
`default_nettype wire
